### design/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg
// Field widths and opcode nibbles shared by the prefix instruction encoder
// and its channel interfaces.
// ----------------------------------------------------------------------------
package pie_pkg;

    localparam int FC_W   = 4;   // function code
    localparam int OPND_W = 32;  // operand as it arrives
    localparam int LEN_W  = 5;   // slot_length / total_length
    localparam int BYTE_W = 8;   // one code byte
    localparam int NIB_W  = 4;

    // longest sequence the result channel can carry
    localparam int RESULT_LIMIT = 16;

    localparam logic [NIB_W-1:0] PFX_OP = 4'h2;
    localparam logic [NIB_W-1:0] NFX_OP = 4'h6;

    localparam logic [BYTE_W-1:0] PFX_ZERO_BYTE = {PFX_OP, 4'h0};
    localparam logic [BYTE_W-1:0] ERR_BYTE      = 8'h00;

endpackage

### design/pie_in_if.sv
// ----------------------------------------------------------------------------
// pie_in_if
// Instruction channel: function code, operand and slot length.
// ----------------------------------------------------------------------------
interface pie_in_if;
    import pie_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FC_W-1:0]          function_code;
    logic signed [OPND_W-1:0] operand;
    logic [LEN_W-1:0]         slot_length;

    modport source (output valid, output function_code, output operand,
                    output slot_length, input ready);
    modport sink   (input valid, input function_code, input operand,
                    input slot_length, output ready);
endinterface

### design/pie_out_if.sv
// ----------------------------------------------------------------------------
// pie_out_if
// Byte channel: one code byte per transaction with last and error marks.
// ----------------------------------------------------------------------------
interface pie_out_if;
    import pie_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic              last_byte;
    logic              no_fit;
    logic [LEN_W-1:0]  total_length;

    modport source (output valid, output code_byte, output last_byte,
                    output no_fit, output total_length, input ready);
    modport sink   (input valid, input code_byte, input last_byte,
                    input no_fit, input total_length, output ready);
endinterface

### design/prefix_instruction_encoder_top.sv
// ----------------------------------------------------------------------------
// prefix_instruction_encoder_top
// Encodes a direct instruction with pfix/nfix prefixes into a byte stream.
// ----------------------------------------------------------------------------
// Each instruction transaction becomes a run of code bytes, most significant
// first, with last_byte on the final one; a sequence that does not fit its
// slot (or MAX_LENGTH when the slot is 0) gives a single byte with no_fit and
// last_byte set and total_length holding the natural length. Three register
// stages sign-extend the operand, find the highest significant nibble and
// build the byte list; the first byte is sent from the serializer register
// that follows stage 3. The serializer sends one byte per cycle while
// code.ready is high, so an instruction takes total_length bytes of the
// byte channel (one byte on a no-fit), and it sets the sustained rate.
// ----------------------------------------------------------------------------
module prefix_instruction_encoder_top #(
    parameter int MAX_LENGTH = 8,
    parameter int WORD_BITS  = 32,
    parameter int SLOT_MAX   = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    pie_in_if.sink   instr,
    pie_out_if.source code
);
    import pie_pkg::*;

    localparam int NIBS      = (WORD_BITS + NIB_W - 1) / NIB_W;
    localparam int PAD_W     = NIBS * NIB_W;
    localparam int IDX_W     = $clog2(NIBS);
    localparam int LEN_LIM   = (MAX_LENGTH < RESULT_LIMIT) ? MAX_LENGTH : RESULT_LIMIT;
    localparam int SLOT_LIM  = (SLOT_MAX < RESULT_LIMIT) ? SLOT_MAX : RESULT_LIMIT;
    localparam logic [LEN_W-1:0] LEN_LIM_V  = LEN_W'(LEN_LIM);
    localparam logic [LEN_W-1:0] SLOT_LIM_V = LEN_W'(SLOT_LIM);

    // ------------------------------------------------------------------
    // handshake chain
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic ser_valid_reg, ser_valid_next;
    logic s1_ready, s2_ready, s3_ready, ser_free;
    logic in_take;
    logic [LEN_W-1:0] ser_cnt_reg, ser_cnt_next;

    assign ser_free    = !ser_valid_reg || (code.ready && (ser_cnt_reg == '0));
    assign s3_ready    = !s3_valid_reg || ser_free;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign instr.ready = s1_ready;
    assign in_take     = instr.valid && s1_ready;

    // ------------------------------------------------------------------
    // stage 1: operand reduced to the machine word
    // ------------------------------------------------------------------
    logic [FC_W-1:0]      s1_fc_reg;
    logic [WORD_BITS-1:0] s1_w_reg;
    logic [LEN_W-1:0]     s1_slot_reg;
    logic [63:0]          op_ext;

    assign op_ext = {{32{instr.operand[OPND_W-1]}}, instr.operand};

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_fc_reg   <= instr.function_code;
            s1_w_reg    <= op_ext[WORD_BITS-1:0];
            s1_slot_reg <= instr.slot_length;
        end
    end

    // nibbles of w (nonnegative) or ~w (negative) that carry information
    logic             s1_neg;
    logic [PAD_W-1:0] s1_w_pad, s1_t_pad;
    logic [NIBS-1:0]  s1_nz;

    assign s1_neg   = s1_w_reg[WORD_BITS-1];
    assign s1_w_pad = PAD_W'(s1_w_reg);
    assign s1_t_pad = s1_neg ? PAD_W'(~s1_w_reg) : PAD_W'(s1_w_reg);

    always_comb
    begin
        s1_nz = '0;
        for (int j = 1; j < NIBS; j++)
        begin
            s1_nz[j] = |s1_t_pad[NIB_W*j +: NIB_W];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: highest significant nibble
    // ------------------------------------------------------------------
    logic [FC_W-1:0]  s2_fc_reg;
    logic [PAD_W-1:0] s2_w_reg, s2_t_reg;
    logic             s2_neg_reg;
    logic [LEN_W-1:0] s2_slot_reg;
    logic [NIBS-1:0]  s2_nz_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_fc_reg   <= s1_fc_reg;
            s2_w_reg    <= s1_w_pad;
            s2_t_reg    <= s1_t_pad;
            s2_neg_reg  <= s1_neg;
            s2_slot_reg <= s1_slot_reg;
            s2_nz_reg   <= s1_nz;
        end
    end

    // negative operands always carry an nfix, so the top index is at least 1
    logic [IDX_W-1:0] s2_top;

    always_comb
    begin
        s2_top = s2_neg_reg ? IDX_W'(1) : '0;
        for (int j = 1; j < NIBS; j++)
        begin
            if (s2_nz_reg[j])
            begin
                s2_top = IDX_W'(j);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: byte list, length and fit check
    // ------------------------------------------------------------------
    logic [FC_W-1:0]  s3_fc_reg;
    logic [PAD_W-1:0] s3_w_reg, s3_t_reg;
    logic             s3_neg_reg;
    logic [LEN_W-1:0] s3_slot_reg;
    logic [IDX_W-1:0] s3_top_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            s3_fc_reg   <= s2_fc_reg;
            s3_w_reg    <= s2_w_reg;
            s3_t_reg    <= s2_t_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_slot_reg <= s2_slot_reg;
            s3_top_reg  <= s2_top;
        end
    end

    logic [LEN_W-1:0]  s3_len;
    logic [LEN_W-1:0]  s3_total;
    logic              s3_fits;
    logic [BYTE_W-1:0] s3_rev [NIBS];

    assign s3_len = LEN_W'(s3_top_reg) + LEN_W'(1);

    always_comb
    begin
        if (s3_slot_reg == '0)
        begin
            s3_fits  = (s3_len <= LEN_LIM_V);
            s3_total = s3_len;
        end
        else
        begin
            s3_fits  = (s3_slot_reg <= SLOT_LIM_V) && (s3_len <= s3_slot_reg);
            s3_total = s3_slot_reg;
        end
    end

    // byte i counted from the end of the sequence
    always_comb
    begin
        for (int i = 0; i < NIBS; i++)
        begin
            if (i == 0)
            begin
                s3_rev[i] = {s3_fc_reg, s3_w_reg[NIB_W-1:0]};
            end
            else if (s3_neg_reg && (IDX_W'(i) == s3_top_reg))
            begin
                s3_rev[i] = {NFX_OP, s3_t_reg[NIB_W*i +: NIB_W]};
            end
            else
            begin
                s3_rev[i] = {PFX_OP, s3_w_reg[NIB_W*i +: NIB_W]};
            end
        end
    end

    // ------------------------------------------------------------------
    // output serializer: counts down from the first byte to the last
    // ------------------------------------------------------------------
    logic              ser_load;
    logic              ser_err_reg;
    logic [LEN_W-1:0]  ser_len_reg;
    logic [LEN_W-1:0]  ser_total_reg;
    logic [BYTE_W-1:0] rev_reg [NIBS];

    assign ser_load = s3_valid_reg && ser_free;

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_err_reg   <= !s3_fits;
            ser_len_reg   <= s3_len;
            ser_total_reg <= s3_fits ? s3_total : s3_len;
            rev_reg       <= s3_rev;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        s3_valid_next  = s3_valid_reg;
        ser_valid_next = ser_valid_reg;
        ser_cnt_next   = ser_cnt_reg;

        if (s1_ready)
        begin
            s1_valid_next = instr.valid;
        end
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
        if (s3_ready)
        begin
            s3_valid_next = s2_valid_reg;
        end

        if (ser_free)
        begin
            ser_valid_next = s3_valid_reg;
            ser_cnt_next   = s3_fits ? (s3_total - LEN_W'(1)) : '0;
        end
        else if (code.ready)
        begin
            ser_cnt_next = ser_cnt_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
        end
    end

    // counts at or above the natural length are left padding
    always_comb
    begin
        if (ser_err_reg)
        begin
            code.code_byte = ERR_BYTE;
        end
        else if (ser_cnt_reg >= ser_len_reg)
        begin
            code.code_byte = PFX_ZERO_BYTE;
        end
        else
        begin
            code.code_byte = rev_reg[ser_cnt_reg[IDX_W-1:0]];
        end
    end

    assign code.valid        = ser_valid_reg;
    assign code.last_byte    = (ser_cnt_reg == '0);
    assign code.no_fit       = ser_err_reg;
    assign code.total_length = ser_total_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_nofit_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid && code.no_fit |-> code.last_byte)
        else $error("no_fit transaction without last_byte");

    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid |-> (code.total_length != '0)
                       && (ser_cnt_reg < code.total_length))
        else $error("byte count outside sequence length");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid && code.ready && !code.last_byte
        |=> code.valid && (ser_cnt_reg == $past(ser_cnt_reg) - LEN_W'(1)))
        else $error("serializer did not step to the next byte");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !instr.ready |-> s1_valid_reg && s2_valid_reg && s3_valid_reg
                         && ser_valid_reg)
        else $error("input stalled with a free pipeline slot");

endmodule

### verif/prefix_instruction_encoder_top_test.sv
// ----------------------------------------------------------------------------
// prefix_instruction_encoder_top_test
// Self-checking bench for the pfix/nfix prefix instruction encoder.
// ----------------------------------------------------------------------------
// A short table of hand-picked instructions goes first: zero, the operand
// extremes, small negatives that need only an nfix, padded slots and every
// kind of no-fit. Rows whose bytes are obvious carry them inline. The other
// rows go through a local encoder model. Random instructions follow in three
// back-pressure phases, and every code byte is compared field by field.
// ----------------------------------------------------------------------------
module prefix_instruction_encoder_top_test;
    import pie_pkg::*;

    localparam int MAX_LEN          = 8;
    localparam int WORD_W           = 32;
    localparam int SLOT_LIM         = 16;
    localparam int NATURAL_CAP      = (MAX_LEN < RESULT_LIMIT) ? MAX_LEN : RESULT_LIMIT;
    localparam int N_DIRECTED       = 24;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int DRAIN_CYCLES     = 20;
    localparam int STALL_LIMIT      = 4000;

    // one table row; bytes in seq are left aligned, first byte in [63:56]
    typedef struct packed {
        logic [FC_W-1:0]   fc;
        logic [OPND_W-1:0] opnd;
        logic [LEN_W-1:0]  slot;
        bit                known;
        bit                nofit;
        logic [LEN_W-1:0]  nbytes;
        logic [63:0]       seq;
    } instr_row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        bit                last_byte;
        bit                no_fit;
        logic [LEN_W-1:0]  total_length;
    } code_beat_t;

    logic clk;
    logic rst_n;

    pie_in_if  instr_ch ();
    pie_out_if code_ch ();

    prefix_instruction_encoder_top #(
        .MAX_LENGTH (MAX_LEN),
        .WORD_BITS  (WORD_W),
        .SLOT_MAX   (SLOT_LIM)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .instr (instr_ch),
        .code  (code_ch)
    );

    code_beat_t expected_bytes[$];
    instr_row_t directed_rows [0:N_DIRECTED-1];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int instr_count;
    int bytes_checked;
    int nofit_seen;
    int padded_count;
    int stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Encoder model: pushes the expected code bytes of one instruction.
    function automatic void push_encoding(input logic [FC_W-1:0] fc,
                                          input logic [OPND_W-1:0] opnd,
                                          input logic [LEN_W-1:0] slot);
        logic [BYTE_W-1:0] body[$];
        logic [OPND_W-1:0] rest;
        code_beat_t        beat;
        int                natural;
        int                span;
        bit                fits;

        body.push_front({fc, opnd[NIB_W-1:0]});
        if (!opnd[OPND_W-1])
        begin
            rest = opnd >> NIB_W;
            while (rest != 0)
            begin
                body.push_front({PFX_OP, rest[NIB_W-1:0]});
                rest = rest >> NIB_W;
            end
        end
        else
        begin
            // complemented nibbles; the closing nfix supplies the sign
            rest = (~opnd) >> NIB_W;
            while (rest >= 16)
            begin
                body.push_front({PFX_OP, ~rest[NIB_W-1:0]});
                rest = rest >> NIB_W;
            end
            body.push_front({NFX_OP, rest[NIB_W-1:0]});
        end

        natural = body.size();
        if (slot == 0)
        begin
            fits = natural <= NATURAL_CAP;
            span = natural;
        end
        else
        begin
            fits = slot <= SLOT_LIM && slot <= RESULT_LIMIT && natural <= slot;
            span = slot;
        end

        if (!fits)
        begin
            beat.code_byte    = ERR_BYTE;
            beat.last_byte    = 1'b1;
            beat.no_fit       = 1'b1;
            beat.total_length = LEN_W'(natural);
            expected_bytes.push_back(beat);
        end
        else
        begin
            if (span > natural)
                padded_count++;
            repeat (span - natural)
                body.push_front(PFX_ZERO_BYTE);
            foreach (body[i])
            begin
                beat.code_byte    = body[i];
                beat.last_byte    = (i == span - 1);
                beat.no_fit       = 1'b0;
                beat.total_length = LEN_W'(span);
                expected_bytes.push_back(beat);
            end
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send_instr(input instr_row_t row);
        code_beat_t beat;

        while ($urandom_range(99) < send_idle_pct)
        begin
            instr_ch.valid <= 1'b0;
            @(negedge clk);
        end
        instr_ch.valid         <= 1'b1;
        instr_ch.function_code <= row.fc;
        instr_ch.operand       <= row.opnd;
        instr_ch.slot_length   <= row.slot;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);

        instr_count++;
        if (!row.known)
            push_encoding(row.fc, row.opnd, row.slot);
        else if (row.nofit)
        begin
            beat.code_byte    = ERR_BYTE;
            beat.last_byte    = 1'b1;
            beat.no_fit       = 1'b1;
            beat.total_length = row.nbytes;
            expected_bytes.push_back(beat);
        end
        else
        begin
            for (int i = 0; i < row.nbytes; i++)
            begin
                beat.code_byte    = row.seq[63 - 8*i -: 8];
                beat.last_byte    = (i == row.nbytes - 1);
                beat.no_fit       = 1'b0;
                beat.total_length = row.nbytes;
                expected_bytes.push_back(beat);
            end
        end
        @(negedge clk);
    endtask

    // hold off new instructions until the byte stream has fully drained
    task automatic drain_pause();
        instr_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_bytes.size() != 0)
            @(negedge clk);
    endtask

    // byte channel back-pressure
    initial
    begin
        code_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            code_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && code_ch.valid && code_ch.ready)
        begin
            if (code_ch.no_fit)
                nofit_seen++;
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected code byte %h", code_ch.code_byte));
            else
            begin
                code_beat_t want;
                want = expected_bytes.pop_front();
                if (code_ch.code_byte !== want.code_byte)
                    report_mismatch($sformatf("byte %0d code_byte %h, expected %h",
                                              bytes_checked, code_ch.code_byte,
                                              want.code_byte));
                if (code_ch.last_byte !== want.last_byte)
                    report_mismatch($sformatf("byte %0d last_byte %b, expected %b",
                                              bytes_checked, code_ch.last_byte,
                                              want.last_byte));
                if (code_ch.no_fit !== want.no_fit)
                    report_mismatch($sformatf("byte %0d no_fit %b, expected %b",
                                              bytes_checked, code_ch.no_fit, want.no_fit));
                if (code_ch.total_length !== want.total_length)
                    report_mismatch($sformatf("byte %0d total_length %0d, expected %0d",
                                              bytes_checked, code_ch.total_length,
                                              want.total_length));
            end
            bytes_checked++;
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((instr_ch.valid && instr_ch.ready) || (code_ch.valid && code_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d bytes still expected",
                     stall_cycles, expected_bytes.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        instr_row_t  row;
        logic [31:0] mag;
        int          pick;
        int          nibs;

        instr_ch.valid         = 1'b0;
        instr_ch.function_code = '0;
        instr_ch.operand       = '0;
        instr_ch.slot_length   = '0;
        rst_n                  = 1'b0;
        send_idle_pct          = 15;
        recv_idle_pct          = 48;
        mismatch_count         = 0;
        instr_count            = 0;
        bytes_checked          = 0;
        nofit_seen             = 0;
        padded_count           = 0;
        stall_cycles           = 0;

        //                fc     operand        slot   known nofit len  bytes
        directed_rows = '{
            '{4'd0,  32'h0000_0000, 5'd0,  1'b1, 1'b0, 5'd1, 64'h0000_0000_0000_0000},
            '{4'd15, 32'h0000_000f, 5'd0,  1'b1, 1'b0, 5'd1, 64'hff00_0000_0000_0000},
            '{4'd4,  32'h0000_0010, 5'd0,  1'b1, 1'b0, 5'd2, 64'h2140_0000_0000_0000},
            '{4'd7,  32'h7fff_ffff, 5'd0,  1'b1, 1'b0, 5'd8, 64'h272f_2f2f_2f2f_2f7f},
            '{4'd1,  32'hffff_ffff, 5'd0,  1'b1, 1'b0, 5'd2, 64'h601f_0000_0000_0000},
            '{4'd2,  32'hffff_fff0, 5'd0,  1'b1, 1'b0, 5'd2, 64'h6020_0000_0000_0000},
            '{4'd3,  32'hffff_ffef, 5'd0,  1'b1, 1'b0, 5'd2, 64'h613f_0000_0000_0000},
            '{4'd9,  32'h8000_0000, 5'd0,  1'b1, 1'b0, 5'd8, 64'h6720_2020_2020_2090},
            '{4'd10, 32'hffff_feff, 5'd0,  1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd5,  32'h0000_0100, 5'd2,  1'b1, 1'b1, 5'd3, 64'h0},
            '{4'd0,  32'h0000_0000, 5'd17, 1'b1, 1'b1, 5'd1, 64'h0},
            '{4'd12, 32'h1234_5678, 5'd31, 1'b1, 1'b1, 5'd8, 64'h0},
            '{4'd15, 32'h7fff_ffff, 5'd16, 1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd6,  32'h0000_0005, 5'd1,  1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd8,  32'h0000_0000, 5'd16, 1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd11, 32'h8000_0000, 5'd7,  1'b1, 1'b1, 5'd8, 64'h0},
            '{4'd13, 32'h8000_0000, 5'd8,  1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd14, 32'h0001_0000, 5'd0,  1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd3,  32'hffff_fffe, 5'd3,  1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd14, 32'h0000_ffff, 5'd0,  1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd6,  32'hf000_0000, 5'd12, 1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd10, 32'h5555_5555, 5'd0,  1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd5,  32'haaaa_aaaa, 5'd9,  1'b0, 1'b0, 5'd0, 64'h0},
            '{4'd1,  32'h7fff_ffff, 5'd7,  1'b1, 1'b1, 5'd8, 64'h0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_instr(directed_rows[i]);
        drain_pause();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                row       = '0;
                row.fc    = FC_W'($urandom_range(15));
                pick      = $urandom_range(99);
                if (pick < 45)
                begin
                    // short operands of either sign, all prefix counts
                    nibs = $urandom_range(8);
                    mag  = (nibs == 0) ? 32'h0 : ($urandom >> (OPND_W - NIB_W*nibs));
                    row.opnd = $urandom_range(1) ? ~mag : mag;
                end
                else if (pick < 60)
                begin
                    // at or just under a nibble boundary
                    mag = 32'h1 << (NIB_W * $urandom_range(7));
                    mag = mag - $urandom_range(1);
                    row.opnd = $urandom_range(1) ? -mag : mag;
                end
                else
                    row.opnd = $urandom;

                pick = $urandom_range(99);
                if (pick < 50)
                    row.slot = '0;
                else if (pick < 85)
                    row.slot = LEN_W'($urandom_range(16, 1));
                else if (pick < 95)
                    row.slot = LEN_W'($urandom_range(4, 1));
                else
                    row.slot = LEN_W'($urandom_range(31, 17));
                send_instr(row);
            end
            drain_pause();
        end

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d instructions (%0d from the table), %0d code bytes compared.",
                 instr_count, N_DIRECTED, bytes_checked);
        $display("Seen: %0d no-fit results, %0d padded sequences, %0d mismatches.",
                 nofit_seen, padded_count, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
design/pie_pkg.sv
design/pie_in_if.sv
design/pie_out_if.sv
design/prefix_instruction_encoder_top.sv
verif/prefix_instruction_encoder_top_test.sv
